[src/sida_pkg.sv]
`default_nettype none

package sida_pkg;

    // Places a 16-bit magnitude can fill; any further places hold only zeros.
    localparam int MAX_PLACES         = 5;
    localparam int DIGIT_PLACES_DEF   = 5;

    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam logic [5:0] CHAR_ZERO  = 6'd48;

    typedef logic [3:0] t_digit;

    // Split 0..99 into tens and ones; tens = x * 205 >> 11 is exact below 1024.
    function automatic logic [7:0] f_split_tens(input logic [6:0] x);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(x) * 15'd205;
        tens = prod[14:11];
        ones = x - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

endpackage

`default_nettype wire

[src/signed_int_to_decimal_ascii.sv]
// An input value passes the input register, the split register and the emitter register before its first character.
// Throughput: one character per cycle while i_stall is low; a value gives 2 to 6 characters,
//   one per place (optional minus sign plus the digits), all through the single output port.
// Input transfers continue while earlier values are being emitted (three-stage pipeline).
// Reset (synchronous, active low) empties every stage; payload registers are not reset.
`default_nettype none

module signed_int_to_decimal_ascii #(
    parameter int DIGIT_PLACES = sida_pkg::DIGIT_PLACES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_value,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [5:0]       o_char_code,
    output logic             o_is_last
);
    import sida_pkg::*;

    // Places that can show up in the text: a 16-bit magnitude never reaches a sixth place,
    // and fewer places drop the high digits (value modulo 10^places).
    localparam int NUM_DIGITS = (DIGIT_PLACES < MAX_PLACES) ? DIGIT_PLACES : MAX_PLACES;
    localparam int PLACE_W    = $clog2(NUM_DIGITS);

    // ---------------------------------------------------------------
    // Stage control. Each stage advances when the one after it frees.
    // ---------------------------------------------------------------
    logic r1_valid, r2_valid, r3_valid;
    logic n1_valid, n2_valid, n3_valid;
    logic load1, load2, load3;
    logic out_take, s3_last, s3_free;

    // emitter registers
    logic               r3_sign;
    t_digit             r3_dig [NUM_DIGITS];
    logic [PLACE_W-1:0] r3_place;

    assign s3_last  = !r3_sign && (r3_place == '0);
    assign out_take = r3_valid && !i_stall;
    // The emitter frees on the transfer of its last character.
    assign s3_free  = !r3_valid || (out_take && s3_last);
    assign load3    = r2_valid && s3_free;
    assign load2    = r1_valid && (!r2_valid || load3);
    assign o_stall  = r1_valid && !load2;
    assign load1    = i_valid && !o_stall;

    always_comb begin
        n1_valid = r1_valid;
        if (load1) begin
            n1_valid = 1'b1;
        end else if (load2) begin
            n1_valid = 1'b0;
        end

        n2_valid = r2_valid;
        if (load2) begin
            n2_valid = 1'b1;
        end else if (load3) begin
            n2_valid = 1'b0;
        end

        n3_valid = r3_valid;
        if (load3) begin
            n3_valid = 1'b1;
        end else if (out_take && s3_last) begin
            n3_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= n1_valid;
            r2_valid <= n2_valid;
            r3_valid <= n3_valid;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: input register. Stage 1 -> 2: magnitude, split by 100.
    // ---------------------------------------------------------------
    logic [15:0] r1_value;
    logic [15:0] mag;
    logic [28:0] prod_hi;
    logic [8:0]  quo_hi;
    logic [15:0] rem_lo;

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r1_value <= i_value;
        end
    end

    // Two's complement negation in 16 bits; -32768 maps onto 32768 by itself.
    assign mag     = r1_value[15] ? (~r1_value + 16'd1) : r1_value;
    // mag / 100 as mag * 5243 >> 19, exact for every magnitude below 43690.
    assign prod_hi = 29'(mag) * 29'd5243;
    assign quo_hi  = prod_hi[27:19];
    assign rem_lo  = mag - 16'(quo_hi) * 16'd100;

    logic       r2_neg;
    logic [8:0] r2_hi;
    logic [6:0] r2_lo;

    always_ff @(posedge i_clk) begin
        if (load2) begin
            r2_neg <= r1_value[15];
            r2_hi  <= quo_hi;
            r2_lo  <= rem_lo[6:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2 -> 3: five decimal digits and the first place to show.
    // ---------------------------------------------------------------
    logic [14:0]        prod_top;
    logic [1:0]         quo_top;
    logic [8:0]         rem_mid;
    logic [7:0]         pair_mid, pair_lo;
    t_digit             dig [MAX_PLACES];
    logic [PLACE_W-1:0] start_place;

    // r2_hi / 100 as r2_hi * 41 >> 12, exact below 400 (the quotient keeps 2 bits).
    assign prod_top = 15'(r2_hi) * 15'd41;
    assign quo_top  = prod_top[13:12];
    assign rem_mid  = r2_hi - 9'(quo_top) * 9'd100;
    assign pair_mid = f_split_tens(rem_mid[6:0]);
    assign pair_lo  = f_split_tens(r2_lo);

    always_comb begin
        dig[4] = {2'b00, quo_top};
        dig[3] = pair_mid[7:4];
        dig[2] = pair_mid[3:0];
        dig[1] = pair_lo[7:4];
        dig[0] = pair_lo[3:0];

        // Tens place always shows; a higher place shows from its first nonzero digit.
        start_place = PLACE_W'(1);
        for (int p = 2; p < NUM_DIGITS; p++) begin
            if (dig[p] != '0) begin
                start_place = PLACE_W'(p);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: character emitter. Sign first, then digits down to place 0.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (load3) begin
            r3_sign  <= r2_neg;
            r3_place <= start_place;
            for (int p = 0; p < NUM_DIGITS; p++) begin
                r3_dig[p] <= dig[p];
            end
        end else if (out_take && !s3_last) begin
            // advance: drop the sign, else step down one place
            if (r3_sign) begin
                r3_sign <= 1'b0;
            end else begin
                r3_place <= r3_place - PLACE_W'(1);
            end
        end
    end

    assign o_valid     = r3_valid;
    assign o_char_code = r3_sign ? CHAR_MINUS : (CHAR_ZERO + {2'b00, r3_dig[r3_place]});
    assign o_is_last   = s3_last;

endmodule

`default_nettype wire

[src/sida_check.sv]
`default_nettype none

module sida_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [15:0] i_value,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [5:0]  o_char_code,
    input wire logic        o_is_last
);
    import sida_pkg::*;

    // Hold a stalled character.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_char_code) && $stable(o_is_last))
        else $error("stalled output character changed");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == CHAR_MINUS)
                 || ((o_char_code >= CHAR_ZERO) && (o_char_code <= CHAR_ZERO + 6'd9)))
        else $error("character outside sign and digit codes");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_char_code == CHAR_MINUS) |-> !o_is_last)
        else $error("minus sign marked as last character");

    a_digit_after_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && (o_char_code == CHAR_MINUS)
            |=> o_valid && (o_char_code != CHAR_MINUS))
        else $error("minus sign not followed by a digit");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind signed_int_to_decimal_ascii sida_check u_sida_check (.*);

`default_nettype wire

[tb/sv/sida_text_monitor.sv]
module sida_text_monitor #(
    parameter int DIGIT_PLACES = sida_pkg::DIGIT_PLACES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [15:0] i_in_value,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [5:0]  i_out_char_code,
    input  logic        i_out_is_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_values_seen,
    output int          o_negatives_seen,
    output int          o_chars_seen
);

    typedef struct packed {
        logic [5:0] code;
        logic       last;
    } t_text_char;

    t_text_char pending_chars[$];
    int         fails     = 0;
    int         values    = 0;
    int         negatives = 0;
    int         chars     = 0;

    // Append the characters that one value should produce.
    function automatic void predict_text(input logic [15:0] value);
        t_text_char      text[$];
        t_text_char      tail;
        logic [15:0]     magnitude;
        longint unsigned weight;
        longint unsigned rem;
        longint unsigned digit;
        int              places;
        int              p;
        bit              started;

        places  = DIGIT_PLACES;
        started = 1'b0;
        weight  = 1;
        if (places < 2) begin
            places = 2;
        end
        if (places > 10) begin
            places = 10;
        end

        // Two's complement negation wraps 0x8000 onto itself: magnitude 32768.
        if (value[15]) begin
            text.push_back('{sida_pkg::CHAR_MINUS, 1'b0});
            magnitude = ~value + 16'd1;
        end else begin
            magnitude = value;
        end

        for (p = 1; p < places; p++) begin
            weight *= 10;
        end
        rem = 64'(magnitude) % (weight * 10);

        // Suppress leading zeros, but always emit tens and units.
        for (p = places - 1; p >= 0; p--) begin
            digit = rem / weight;
            rem   = rem - digit * weight;
            if (digit != 0 || p <= 1) begin
                started = 1'b1;
            end
            if (started && text.size() < 6) begin
                text.push_back('{sida_pkg::CHAR_ZERO + 6'(digit), 1'b0});
            end
            if (weight >= 10) begin
                weight /= 10;
            end
        end

        tail      = text.pop_back();
        tail.last = 1'b1;
        text.push_back(tail);
        foreach (text[i]) begin
            pending_chars.push_back(text[i]);
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                chars++;
                if (pending_chars.size() == 0) begin
                    fails++;
                    $error("char_code %0d arrived with no character expected", i_out_char_code);
                end else begin
                    want = pending_chars.pop_front();
                    if (i_out_char_code !== want.code) begin
                        fails++;
                        $error("char_code mismatch: expected %0d, got %0d",
                               want.code, i_out_char_code);
                    end
                    if (i_out_is_last !== want.last) begin
                        fails++;
                        $error("is_last mismatch: expected %0d, got %0d",
                               want.last, i_out_is_last);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                values++;
                if (i_in_value[15]) begin
                    negatives++;
                end
                predict_text(i_in_value);
            end
        end
        o_fail_count     <= fails;
        o_pending        <= pending_chars.size();
        o_values_seen    <= values;
        o_negatives_seen <= negatives;
        o_chars_seen     <= chars;
    end

endmodule

[tb/sv/tb_signed_int_to_decimal_ascii.sv]
module tb_signed_int_to_decimal_ascii;

    localparam int PLACES         = sida_pkg::DIGIT_PLACES_DEF;
    // Long enough that a full pipeline backs up onto the input.
    localparam int HOLD_CYCLES    = 64;
    // No transfer for this many cycles means the block has hung.
    localparam int WATCHDOG_LIMIT = 1000;
    // Idle time after the final drain; leave margin for strays.
    localparam int SETTLE_CYCLES  = 8;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [15:0] i_value = '0;
    logic        i_stall = 1'b0;

    logic        o_stall;
    logic        o_valid;
    logic [5:0]  o_char_code;
    logic        o_is_last;

    int fail_count;
    int pending;
    int values_seen;
    int negatives_seen;
    int chars_seen;

    // Idle percentages, changed per phase by the main sequence.
    int send_idle_pct      = 25;
    int recv_idle_pct      = 59;
    // Set by the main sequence; the receiver clears it when it starts holding.
    bit hold_pending       = 1'b0;
    int idle_cycles        = 0;
    int input_stall_cycles = 0;

    initial begin
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    signed_int_to_decimal_ascii #(
        .DIGIT_PLACES(PLACES)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_is_last   (o_is_last)
    );

    sida_text_monitor #(
        .DIGIT_PLACES(PLACES)
    ) monitor (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_in_value       (i_value),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_out_char_code  (o_char_code),
        .i_out_is_last    (o_is_last),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_values_seen    (values_seen),
        .o_negatives_seen (negatives_seen),
        .o_chars_seen     (chars_seen)
    );

    // Receiver: stall at random, or hold off for a long stretch on request.
    // At most one nonblocking write to i_stall per clock edge.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Watchdog: count cycles without any transfer on either channel.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (i_valid && o_stall) begin
                input_stall_cycles <= input_stall_cycles + 1;
            end
        end
    end

    // Offer one value after a random gap; hold it until the transfer happens.
    task automatic send_value(input logic [15:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Mix of full-range values, small magnitudes around zero, values next to
    // powers of ten (where the digit count changes) and wide negatives.
    function automatic logic [15:0] random_value();
        int          m;
        int          pow10;
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0: begin
                v = 16'($urandom);
            end
            1: begin
                m = int'($urandom_range(0, 400)) - 200;
                v = 16'(m);
            end
            2: begin
                pow10 = 10 ** $urandom_range(1, 4);
                m     = pow10 + int'($urandom_range(0, 2)) - 1;
                v     = ($urandom_range(0, 1) == 1) ? 16'(-m) : 16'(m);
            end
            default: begin
                v = 16'($urandom) | 16'h8000;
            end
        endcase
        return v;
    endfunction

    task automatic send_random(input int count);
        repeat (count) begin
            send_value(random_value());
        end
    endtask

    // Drop valid and wait until every expected character has come out.
    // The first edge lets the monitor count the last accepted value.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase 1: sender idles lightly, receiver heavily.
        send_idle_pct = 25;
        recv_idle_pct = 59;

        // Corners: zero and single digits get a forced leading zero.
        send_value(16'd0);
        send_value(16'd5);
        send_value(16'd9);
        send_value(16'd10);
        send_value(16'd99);
        send_value(16'd100);
        send_value(16'd999);
        send_value(16'd1000);
        send_value(16'd9999);
        send_value(16'd10000);
        send_value(16'd10001);
        send_value(16'd12345);
        // Largest positive; with 0 and the most negative value every bit toggles.
        send_value(16'h7FFF);
        send_value(16'(-1));
        send_value(16'(-5));
        send_value(16'(-10));
        send_value(16'(-9999));
        send_value(16'(-32767));
        // Most negative: negation wraps, magnitude still 32768.
        send_value(16'h8000);
        send_value(16'h5555);
        send_value(16'hAAAA);
        send_random(30);
        wait_drained();

        // Phase 2: the other way round.
        send_idle_pct = 59;
        recv_idle_pct = 25;
        send_random(30);
        wait_drained();

        // Phase 3: no idling, plus a long receiver hold-off while values keep
        // coming, so the pipeline fills and stalls its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(10);
        hold_pending = 1'b1;
        send_random(12);
        send_random(10);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Summary: %0d values (%0d negative) converted into %0d characters",
                 values_seen, negatives_seen, chars_seen);
        $display("Summary: input stalled by the block for %0d cycles, %0d mismatches",
                 input_stall_cycles, fail_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
src/sida_pkg.sv
src/signed_int_to_decimal_ascii.sv
src/sida_check.sv
tb/sv/sida_text_monitor.sv
tb/sv/tb_signed_int_to_decimal_ascii.sv
